/* src/sbmf_pkg.sv */
// Package for the separable box max filter: widths, register indexes, reset
// values, pixel types and the lane control struct. No dependencies.
`timescale 1ns / 1ps

package sbmf_pkg;

    localparam int PIX_W     = 16;
    localparam int LANES     = 4;
    localparam int CFG_W     = 11;
    localparam int RAD_CFG_W = 4;
    localparam int STEP_W    = 21;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd2;

    localparam logic [CFG_W-1:0]     RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [CFG_W-1:0]     RST_FRAME_HEIGHT = 11'd1024;
    localparam logic [RAD_CFG_W-1:0] RST_RADIUS       = 4'd4;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_RADIUS = 8;

    typedef logic [PIX_W-1:0]       comp_t;
    typedef logic [LANES*PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic clear;
        logic h_en;
        logic v_en;
        logic use_h;
    } lane_ctl_t;

    function automatic comp_t comp_max(comp_t a, comp_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* src/sbmf_if.sv */
// Stream interfaces for the pixel input and the filtered pixel output.
// Depends on sbmf_pkg.
`timescale 1ns / 1ps

interface sbmf_in_if;
    logic              valid;
    logic              ready;
    logic              is_pad;
    sbmf_pkg::comp_t   in_red;
    sbmf_pkg::comp_t   in_green;
    sbmf_pkg::comp_t   in_blue;
    sbmf_pkg::comp_t   in_alpha;

    modport source (output valid, is_pad, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, is_pad, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface sbmf_out_if;
    logic              valid;
    logic              ready;
    sbmf_pkg::comp_t   out_red;
    sbmf_pkg::comp_t   out_green;
    sbmf_pkg::comp_t   out_blue;
    sbmf_pkg::comp_t   out_alpha;
    logic              last;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, last, output ready);
endinterface

/* src/sbmf_lane.sv */
// One colour channel lane: accumulates the horizontal and vertical maxima.
// Depends on sbmf_pkg.
`timescale 1ns / 1ps

module sbmf_lane (
    input  logic                clk,
    input  sbmf_pkg::lane_ctl_t ctl,
    input  sbmf_pkg::comp_t     h_data,
    input  sbmf_pkg::comp_t     v_data,
    output sbmf_pkg::comp_t     hm,
    output sbmf_pkg::comp_t     res
);
    import sbmf_pkg::*;

    comp_t h_reg;
    comp_t h_next;
    comp_t v_reg;
    comp_t v_next;

    always_comb
    begin
        h_next = h_reg;
        v_next = v_reg;
        if (ctl.clear)
        begin
            h_next = '0;
            v_next = '0;
        end
        else
        begin
            if (ctl.h_en)
            begin
                h_next = comp_max(h_reg, h_data);
            end
            if (ctl.v_en)
            begin
                v_next = comp_max(v_reg, v_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        v_reg <= v_next;
    end

    assign hm  = h_reg;
    assign res = comp_max(v_reg, ctl.use_h ? h_reg : '0);

endmodule

/* src/sbmf_line_store.sv */
// Line store of horizontal maxima: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sbmf_line_store #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 64
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/separable_box_max_filter.sv */
// Top level of the separable box max filter: control sequencer, four channel
// lanes, line store and output register. Depends on sbmf_pkg, sbmf_if,
// sbmf_lane and sbmf_line_store.
//
//  port     dir   transfer carries
//  px_in    sink  is_pad, in_red, in_green, in_blue, in_alpha
//  px_out   src   out_red, out_green, out_blue, out_alpha, last
//  cfg_*    in    register write, no handshake
//
// A counted item passes through the decode, run and finish states from transfer to
// next ready; one line store row is read per cycle of the run state through its
// single read port. A pad during the pixel phase is dropped in the decode state.
// Reset clears control state and the row window; the line store is not cleared.
// A pending result waits in the output register; the lanes stall only if a
// second result is ready before the first is taken.
`timescale 1ns / 1ps

module separable_box_max_filter #(
    parameter int MAX_WIDTH  = sbmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sbmf_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = sbmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sbmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbmf_pkg::CFG_W-1:0]        cfg_data,
    sbmf_in_if.sink                           px_in,
    sbmf_out_if.source                        px_out
);
    import sbmf_pkg::*;

    localparam int NSLOT = 2 * MAX_RADIUS;
    localparam int SLW   = $clog2(NSLOT);
    localparam int IW    = $clog2(NSLOT + 1);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int DEPTH = NSLOT * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                  + MAX_RADIUS + 1);
    localparam int CMPW  = (TW > STEP_W) ? TW : STEP_W;
    localparam int HW    = ((XW > IW) ? XW : IW) + 1;
    localparam int VW    = ((YW > IW) ? YW : IW) + 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DEC  = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]     frame_width_reg;
    logic [CFG_W-1:0]     frame_height_reg;
    logic [RAD_CFG_W-1:0] radius_reg;

    logic [XW-1:0]   wid_c, wid_reg;
    logic [YW-1:0]   hgt_c, hgt_reg;
    logic [RW-1:0]   rad_c, rad_reg;
    logic [CMPW-1:0] total_c, rw_c;
    logic [CMPW-1:0] total_reg, t_hi_reg, k_lo_reg, k_hi_reg, last_s_reg;

    logic [STEP_W-1:0] step_reg;
    logic [XW-1:0]     tx_reg, kx_reg;
    logic [YW-1:0]     ty_reg, ky_reg;
    logic [SLW-1:0]    ty_slot_reg, ky_slot_reg;

    logic              pad_reg;
    pixel_t            cur_reg;
    logic              have_hm_reg, emit_reg, last_reg;
    logic [IW-1:0]     idx_reg;
    logic [SLW-1:0]    rd_slot_reg;
    logic              rd_valid_reg;

    pixel_t            rw_reg [NSLOT];

    logic              out_valid_reg;
    pixel_t            out_pix_reg;
    logic              out_last_reg;

    logic              accept, fin_go, out_take;
    logic              cfg_hit;
    logic [CMPW-1:0]   s_ext;
    logic              pix_phase, hm_ok, em_ok;
    logic [IW-1:0]     r2;
    logic [HW-1:0]     h_tr;
    logic              h_ok;
    logic [VW-1:0]     v_sum;
    logic              v_ok;
    logic [SLW-1:0]    start_slot;
    logic [SLW-1:0]    elem_idx;
    pixel_t            elem;
    pixel_t            rd_data, hm_pix, res_pix;
    logic [AW-1:0]     rd_addr, wr_addr;
    lane_ctl_t         lctl;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            radius_reg       <= RST_RADIUS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                REG_RADIUS:       radius_reg       <= cfg_data[RAD_CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // only a write to a defined register restarts the frame
    assign cfg_hit = cfg_we
                  && (cfg_index inside {REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_RADIUS});

    // saturated frame geometry and step thresholds
    always_comb
    begin
        if (frame_width_reg == '0)
            wid_c = XW'(1);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            wid_c = XW'(MAX_WIDTH);
        else
            wid_c = XW'(frame_width_reg);
        if (frame_height_reg == '0)
            hgt_c = YW'(1);
        else if (int'(frame_height_reg) > MAX_HEIGHT)
            hgt_c = YW'(MAX_HEIGHT);
        else
            hgt_c = YW'(frame_height_reg);
        if (int'(radius_reg) > MAX_RADIUS)
            rad_c = RW'(MAX_RADIUS);
        else
            rad_c = RW'(radius_reg);
        total_c = CMPW'(wid_c) * CMPW'(hgt_c);
        rw_c    = CMPW'(rad_c) * CMPW'(wid_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wid_reg    <= '0;
            hgt_reg    <= '0;
            rad_reg    <= '0;
            total_reg  <= '0;
            t_hi_reg   <= '0;
            k_lo_reg   <= '0;
            k_hi_reg   <= '0;
            last_s_reg <= '0;
        end
        else
        begin
            wid_reg    <= wid_c;
            hgt_reg    <= hgt_c;
            rad_reg    <= rad_c;
            total_reg  <= total_c;
            t_hi_reg   <= total_c + CMPW'(rad_c);
            k_lo_reg   <= rw_c + CMPW'(rad_c);
            k_hi_reg   <= total_c + rw_c + CMPW'(rad_c);
            last_s_reg <= total_c + rw_c + CMPW'(rad_c) - CMPW'(1);
        end
    end

    // item decode and window checks
    assign accept    = px_in.valid && px_in.ready;
    assign px_in.ready = (state_reg == ST_IDLE);
    assign out_take  = px_out.valid && px_out.ready;
    assign fin_go    = (state_reg == ST_FIN) && (!emit_reg || !out_valid_reg || px_out.ready);

    assign s_ext     = CMPW'(step_reg);
    assign pix_phase = s_ext < total_reg;
    assign hm_ok     = (s_ext >= CMPW'(rad_reg)) && (s_ext < t_hi_reg);
    assign em_ok     = (s_ext >= k_lo_reg) && (s_ext < k_hi_reg);
    assign r2        = IW'({rad_reg, 1'b0});

    assign start_slot = (ky_slot_reg >= SLW'(rad_reg)) ? ky_slot_reg - SLW'(rad_reg)
                      : SLW'(int'(ky_slot_reg) + NSLOT - int'(rad_reg));

    assign h_tr = HW'(tx_reg) + HW'(rad_reg);
    assign h_ok = (HW'(idx_reg) <= h_tr) && (HW'(idx_reg) + HW'(wid_reg) - HW'(1) >= h_tr);

    assign v_sum = VW'(ky_reg) + VW'(idx_reg);
    assign v_ok  = (idx_reg < r2) && (v_sum >= VW'(rad_reg))
                && (v_sum < VW'(hgt_reg) + VW'(rad_reg));

    assign elem_idx = SLW'(idx_reg - IW'(1));
    assign elem     = (idx_reg == '0) ? cur_reg : rw_reg[elem_idx];

    assign rd_addr = AW'(int'(rd_slot_reg) * MAX_WIDTH + int'(kx_reg));
    assign wr_addr = AW'(int'(ty_slot_reg) * MAX_WIDTH + int'(tx_reg));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_DEC;
            ST_DEC:  state_next = (pix_phase && pad_reg) ? ST_IDLE : ST_RUN;
            ST_RUN:  if (idx_reg == r2) state_next = ST_FIN;
            ST_FIN:  if (fin_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            have_hm_reg  <= 1'b0;
            emit_reg     <= 1'b0;
            last_reg     <= 1'b0;
            idx_reg      <= '0;
            rd_slot_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_RUN) && emit_reg && v_ok;
            if (state_reg == ST_DEC)
            begin
                have_hm_reg <= hm_ok;
                emit_reg    <= em_ok;
                last_reg    <= (s_ext == last_s_reg);
                idx_reg     <= '0;
                rd_slot_reg <= start_slot;
            end
            else if (state_reg == ST_RUN)
            begin
                idx_reg     <= idx_reg + IW'(1);
                rd_slot_reg <= (int'(rd_slot_reg) == NSLOT - 1) ? '0 : rd_slot_reg + SLW'(1);
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pad_reg <= px_in.is_pad;
            cur_reg <= {px_in.in_alpha, px_in.in_blue, px_in.in_green, px_in.in_red};
        end
        else if ((state_reg == ST_DEC) && !pix_phase)
        begin
            cur_reg <= '0;
        end
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            ty_slot_reg <= '0;
            kx_reg      <= '0;
            ky_reg      <= '0;
            ky_slot_reg <= '0;
        end
        else if (cfg_hit || (fin_go && emit_reg && last_reg))
        begin
            step_reg    <= '0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            ty_slot_reg <= '0;
            kx_reg      <= '0;
            ky_reg      <= '0;
            ky_slot_reg <= '0;
        end
        else if (fin_go)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (have_hm_reg)
            begin
                if (tx_reg == wid_reg - XW'(1))
                begin
                    tx_reg      <= '0;
                    ty_reg      <= ty_reg + YW'(1);
                    ty_slot_reg <= (int'(ty_slot_reg) == NSLOT - 1) ? '0
                                 : ty_slot_reg + SLW'(1);
                end
                else
                begin
                    tx_reg <= tx_reg + XW'(1);
                end
            end
            if (emit_reg)
            begin
                if (kx_reg == wid_reg - XW'(1))
                begin
                    kx_reg      <= '0;
                    ky_reg      <= ky_reg + YW'(1);
                    ky_slot_reg <= (int'(ky_slot_reg) == NSLOT - 1) ? '0
                                 : ky_slot_reg + SLW'(1);
                end
                else
                begin
                    kx_reg <= kx_reg + XW'(1);
                end
            end
        end
    end

    // recent input pixels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                rw_reg[i] <= '0;
            end
        end
        else if (fin_go)
        begin
            for (int i = NSLOT - 1; i > 0; i--)
            begin
                rw_reg[i] <= rw_reg[i - 1];
            end
            rw_reg[0] <= cur_reg;
        end
    end

    // lanes
    assign lctl.clear = (state_reg == ST_DEC);
    assign lctl.h_en  = (state_reg == ST_RUN) && have_hm_reg && h_ok;
    assign lctl.v_en  = rd_valid_reg;
    assign lctl.use_h = have_hm_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        sbmf_lane u_lane (
            .clk    (clk),
            .ctl    (lctl),
            .h_data (elem[l*PIX_W +: PIX_W]),
            .v_data (rd_data[l*PIX_W +: PIX_W]),
            .hm     (hm_pix[l*PIX_W +: PIX_W]),
            .res    (res_pix[l*PIX_W +: PIX_W])
        );
    end

    sbmf_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (LANES * PIX_W)
    ) u_line_store (
        .clk   (clk),
        .we    (fin_go && have_hm_reg),
        .waddr (wr_addr),
        .wdata (hm_pix),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go && emit_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go && emit_reg)
        begin
            out_pix_reg  <= res_pix;
            out_last_reg <= last_reg;
        end
    end

    assign px_out.valid     = out_valid_reg;
    assign px_out.out_red   = out_pix_reg[0*PIX_W +: PIX_W];
    assign px_out.out_green = out_pix_reg[1*PIX_W +: PIX_W];
    assign px_out.out_blue  = out_pix_reg[2*PIX_W +: PIX_W];
    assign px_out.out_alpha = out_pix_reg[3*PIX_W +: PIX_W];
    assign px_out.last      = out_last_reg;

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && emit_reg) |=> px_out.valid)
        else $error("result lost at end of item");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (idx_reg <= r2))
        else $error("window index beyond span");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && emit_reg && last_reg) |=> (step_reg == '0))
        else $error("frame did not restart after last");

endmodule
